>>> design/dual_axis_pid_with_clamps_defines.svh
// Assertion macros shared by the dual-axis PID regulator RTL.
// Included by the files that carry concurrent assertions; depends on nothing.
`ifndef DUAL_AXIS_PID_WITH_CLAMPS_DEFINES_SVH
`define DUAL_AXIS_PID_WITH_CLAMPS_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define DAPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dapc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DAPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dapc assertion failed");

`else

`define DAPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define DAPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> design/dapc_pkg.sv
// Types, widths and register codes of the dual-axis PID regulator.
// Used by the interfaces, the register block, the axis lane and the top level.
package dapc_pkg;

  localparam int POS_BITS       = 12;
  localparam int GAIN_FRAC_BITS = 12;
  localparam int OUT_FRAC_BITS  = 12;

  localparam int GAIN_W = 16;
  localparam int ILIM_W = 16;
  localparam int OLIM_W = 12;
  localparam int INT_W  = 17;
  localparam int VEL_W  = 13;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;

  // Derived datapath widths.
  localparam int ERR_W  = POS_BITS + 1;
  localparam int DER_W  = POS_BITS + 2;
  localparam int IS_W   = ((INT_W > ERR_W) ? INT_W : ERR_W) + 1;
  localparam int PRD_W  = GAIN_W + 1 + ((INT_W > DER_W) ? INT_W : DER_W);
  localparam int SUM_W  = PRD_W + 2;
  localparam int SH_L   = (OUT_FRAC_BITS > GAIN_FRAC_BITS) ?
                          (OUT_FRAC_BITS - GAIN_FRAC_BITS) : 0;
  localparam int SH_R   = (GAIN_FRAC_BITS > OUT_FRAC_BITS) ?
                          (GAIN_FRAC_BITS - OUT_FRAC_BITS) : 0;
  localparam int SC_W   = SUM_W + SH_L;

  typedef enum logic [CFG_AW-1:0] {
    REG_TARGET_X       = 3'd0,
    REG_TARGET_Y       = 3'd1,
    REG_GAIN_P         = 3'd2,
    REG_GAIN_I         = 3'd3,
    REG_GAIN_D         = 3'd4,
    REG_INTEGRAL_LIMIT = 3'd5,
    REG_OUTPUT_LIMIT   = 3'd6
  } cfg_reg_t;

  localparam logic [GAIN_W-1:0] GAIN_P_RST = 16'd1638;
  localparam logic [GAIN_W-1:0] GAIN_I_RST = 16'd41;
  localparam logic [GAIN_W-1:0] GAIN_D_RST = 16'd205;
  localparam logic [ILIM_W-1:0] ILIM_RST   = 16'd500;
  localparam logic [OLIM_W-1:0] OLIM_RST   = 12'd1229;

  typedef struct packed {
    logic signed [POS_BITS-1:0] target_x;
    logic signed [POS_BITS-1:0] target_y;
    logic [GAIN_W-1:0]          gain_p;
    logic [GAIN_W-1:0]          gain_i;
    logic [GAIN_W-1:0]          gain_d;
    logic [ILIM_W-1:0]          integral_limit;
    logic [OLIM_W-1:0]          output_limit;
  } cfg_t;

  // Pipeline control from the top level to each lane.
  typedef struct packed {
    logic advance;  // all stages move one step
    logic take;     // a request enters the first stage this cycle
  } lane_ctl_t;

endpackage

>>> design/dapc_in_if.sv
// Request channel of the PID regulator: one measured x/y position pair.
// Depends on dapc_pkg for the position width.
interface dapc_in_if;
  import dapc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [POS_BITS-1:0] measured_x;
  logic signed [POS_BITS-1:0] measured_y;

  modport source (output valid, output measured_x, output measured_y, input ready);
  modport sink   (input valid, input measured_x, input measured_y, output ready);
endinterface

>>> design/dapc_out_if.sv
// Result channel of the PID regulator: clamped x/y velocities and clamp flags.
// Depends on dapc_pkg for the velocity width.
interface dapc_out_if;
  import dapc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] velocity_x;
  logic signed [VEL_W-1:0] velocity_y;
  logic                    saturated_x;
  logic                    saturated_y;

  modport source (output valid, output velocity_x, output velocity_y,
                  output saturated_x, output saturated_y, input ready);
  modport sink   (input valid, input velocity_x, input velocity_y,
                  input saturated_x, input saturated_y, output ready);
endinterface

>>> design/dual_axis_pid_with_clamps.sv
// Channel   | Dir | Handshake         | Payload
// in_ch     | in  | valid/ready       | measured_x, measured_y (12-bit signed)
// out_ch    | out | valid/ready       | velocity_x/y (13-bit signed), saturated_x/y
// cfg_*     | in  | write enable only | cfg_index (3 bits), cfg_wdata (16 bits)
//
// One request is taken every cycle unless the output stalls; each result passes through
// the integrator stage, the registered multiplier stage and the output register.
// A result held at the output with out_ch.ready low freezes the whole pipeline.
// Reset clears the integrals, previous errors and valid bits and restores default
// configuration; no clearing pass is needed.
// Depends on dapc_pkg, the channel interfaces, dapc_cfg, dapc_lane and the macros header.
`include "dual_axis_pid_with_clamps_defines.svh"

module dual_axis_pid_with_clamps (
  input  logic                        clk,
  input  logic                        rst_n,
  dapc_in_if.sink                     in_ch,
  dapc_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [dapc_pkg::CFG_AW-1:0] cfg_index,
  input  logic [dapc_pkg::CFG_DW-1:0] cfg_wdata
);
  import dapc_pkg::*;

  cfg_t      cfg;
  lane_ctl_t ctl;
  logic      en;

  logic v1_r;
  logic v2_r;
  logic out_valid_r;

  logic signed [VEL_W-1:0] vel_x;
  logic signed [VEL_W-1:0] vel_y;
  logic                    sat_x;
  logic                    sat_y;
  logic signed [VEL_W-1:0] vel_x_r;
  logic signed [VEL_W-1:0] vel_y_r;
  logic                    sat_x_r;
  logic                    sat_y_r;

  // Everything moves when the output register is empty or being drained.
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;
  assign ctl.advance = en;
  assign ctl.take    = en && in_ch.valid;

  dapc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dapc_lane u_lane_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .cfg       (cfg),
    .target    (cfg.target_x),
    .measured  (in_ch.measured_x),
    .velocity  (vel_x),
    .saturated (sat_x)
  );

  dapc_lane u_lane_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .cfg       (cfg),
    .target    (cfg.target_y),
    .measured  (in_ch.measured_y),
    .velocity  (vel_y),
    .saturated (sat_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= ctl.take;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  // Merge stage: both lanes land in one result register.
  always_ff @(posedge clk) begin
    if (en) begin
      vel_x_r <= vel_x;
      vel_y_r <= vel_y;
      sat_x_r <= sat_x;
      sat_y_r <= sat_y;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.velocity_x  = vel_x_r;
  assign out_ch.velocity_y  = vel_y_r;
  assign out_ch.saturated_x = sat_x_r;
  assign out_ch.saturated_y = sat_y_r;

  `DAPC_ASSERT_NEXT(a_s1_hold, clk, rst_n, v1_r && !en, v1_r)
  `DAPC_ASSERT_NEXT(a_s2_to_out, clk, rst_n, v2_r && en, out_valid_r)
  `DAPC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_r && !out_ch.ready, out_valid_r && $stable(vel_x_r) && $stable(vel_y_r))

endmodule

>>> design/dapc_cfg.sv
// Configuration register file of the PID regulator: targets, gains and limits.
// Depends on dapc_pkg for the register codes and the cfg_t bundle.
module dapc_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [dapc_pkg::CFG_AW-1:0]  cfg_index,
  input  logic [dapc_pkg::CFG_DW-1:0]  cfg_wdata,
  output dapc_pkg::cfg_t               cfg
);
  import dapc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_TARGET_X:       cfg_nxt.target_x       = cfg_wdata[POS_BITS-1:0];
        REG_TARGET_Y:       cfg_nxt.target_y       = cfg_wdata[POS_BITS-1:0];
        REG_GAIN_P:         cfg_nxt.gain_p         = cfg_wdata[GAIN_W-1:0];
        REG_GAIN_I:         cfg_nxt.gain_i         = cfg_wdata[GAIN_W-1:0];
        REG_GAIN_D:         cfg_nxt.gain_d         = cfg_wdata[GAIN_W-1:0];
        REG_INTEGRAL_LIMIT: cfg_nxt.integral_limit = cfg_wdata[ILIM_W-1:0];
        REG_OUTPUT_LIMIT:   cfg_nxt.output_limit   = cfg_wdata[OLIM_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_x       <= '0;
      cfg_r.target_y       <= '0;
      cfg_r.gain_p         <= GAIN_P_RST;
      cfg_r.gain_i         <= GAIN_I_RST;
      cfg_r.gain_d         <= GAIN_D_RST;
      cfg_r.integral_limit <= ILIM_RST;
      cfg_r.output_limit   <= OLIM_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> design/dapc_lane.sv
// One axis of the PID regulator: error, clamped integral, derivative,
// registered gain products and the rescaled, clamped output sum.
// Depends on dapc_pkg and the assertion macros header.
`include "dual_axis_pid_with_clamps_defines.svh"

module dapc_lane (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  dapc_pkg::lane_ctl_t                  ctl,
  input  dapc_pkg::cfg_t                       cfg,
  input  logic signed [dapc_pkg::POS_BITS-1:0] target,
  input  logic signed [dapc_pkg::POS_BITS-1:0] measured,
  output logic signed [dapc_pkg::VEL_W-1:0]    velocity,
  output logic                                 saturated
);
  import dapc_pkg::*;

  // Loop state.
  logic signed [INT_W-1:0] integ_r;
  logic signed [INT_W-1:0] integ_nxt;
  logic signed [ERR_W-1:0] perr_r;

  // First stage: error terms.
  logic signed [ERR_W-1:0] err;
  logic signed [IS_W-1:0]  isum;
  logic signed [IS_W-1:0]  lim_s;
  logic signed [DER_W-1:0] deriv;
  logic signed [ERR_W-1:0] err_s1_r;
  logic signed [DER_W-1:0] der_s1_r;
  logic signed [INT_W-1:0] int_s1_r;

  // Second stage: gain products.
  logic signed [PRD_W-1:0] prod_p;
  logic signed [PRD_W-1:0] prod_d;
  logic signed [PRD_W-1:0] prod_i;
  logic signed [PRD_W-1:0] prod_p_r;
  logic signed [PRD_W-1:0] prod_d_r;
  logic signed [PRD_W-1:0] prod_i_r;

  // Sum, rescale and clamp.
  logic signed [SUM_W-1:0] sum;
  logic signed [SC_W-1:0]  scaled;
  logic signed [SC_W-1:0]  olim_s;

  always_comb begin
    err   = ERR_W'(target) - ERR_W'(measured);
    isum  = IS_W'(integ_r) + IS_W'(err);
    lim_s = IS_W'($signed({1'b0, cfg.integral_limit}));
    if (isum >= lim_s) begin
      integ_nxt = INT_W'(lim_s);
    end else if (isum <= -lim_s) begin
      integ_nxt = INT_W'(-lim_s);
    end else begin
      integ_nxt = INT_W'(isum);
    end
    deriv = DER_W'(err) - DER_W'(perr_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      perr_r  <= '0;
    end else if (ctl.take) begin
      integ_r <= integ_nxt;
      perr_r  <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      err_s1_r <= err;
      der_s1_r <= deriv;
      int_s1_r <= integ_nxt;
    end
  end

  always_comb begin
    prod_p = $signed({1'b0, cfg.gain_p}) * err_s1_r;
    prod_d = $signed({1'b0, cfg.gain_d}) * der_s1_r;
    prod_i = $signed({1'b0, cfg.gain_i}) * int_s1_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      prod_p_r <= prod_p;
      prod_d_r <= prod_d;
      prod_i_r <= prod_i;
    end
  end

  // The right shift is arithmetic, so it rounds toward minus infinity.
  always_comb begin
    sum    = SUM_W'(prod_p_r) + SUM_W'(prod_d_r) + SUM_W'(prod_i_r);
    scaled = (SC_W'(sum) <<< SH_L) >>> SH_R;
    olim_s = SC_W'($signed({1'b0, cfg.output_limit}));
    if (scaled > olim_s) begin
      velocity  = VEL_W'(olim_s);
      saturated = 1'b1;
    end else if (scaled < -olim_s) begin
      velocity  = VEL_W'(-olim_s);
      saturated = 1'b1;
    end else begin
      velocity  = VEL_W'(scaled);
      saturated = 1'b0;
    end
  end

  `DAPC_ASSERT_NEXT(a_integ_bound, clk, rst_n, ctl.take,
    (integ_r <= $past(lim_s)) && (integ_r >= -$past(lim_s)))
  `DAPC_ASSERT_NEXT(a_perr_update, clk, rst_n, ctl.take, perr_r == $past(err))
  `DAPC_ASSERT_NOW(a_sat_value, clk, rst_n, saturated,
    (velocity == VEL_W'(olim_s)) || (velocity == VEL_W'(-olim_s)))

endmodule
